### rtl/vmx_pkg.sv
// shared constants, opcodes and types of the register vm execute block
`timescale 1ns / 1ps
`default_nettype none
package vmx_pkg;

  localparam int NumRegs    = 16;
  localparam int MemBytes   = 4096;
  localparam int StackDepth = 64;

  localparam int RegAw = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int MemAw = (MemBytes > 1) ? $clog2(MemBytes) : 1;
  localparam int StkAw = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int SpW   = $clog2(StackDepth + 1);

  localparam logic [4:0] ShiftMask = 5'h1F;

  localparam logic [5:0] OpLoad  = 6'd1;
  localparam logic [5:0] OpStore = 6'd2;
  localparam logic [5:0] OpAdd   = 6'd3;
  localparam logic [5:0] OpSub   = 6'd4;
  localparam logic [5:0] OpMul   = 6'd5;
  localparam logic [5:0] OpDiv   = 6'd6;
  localparam logic [5:0] OpJmp   = 6'd7;
  localparam logic [5:0] OpJz    = 6'd8;
  localparam logic [5:0] OpJnz   = 6'd9;
  localparam logic [5:0] OpCall  = 6'd10;
  localparam logic [5:0] OpRet   = 6'd11;
  localparam logic [5:0] OpPush  = 6'd12;
  localparam logic [5:0] OpPop   = 6'd13;
  localparam logic [5:0] OpAnd   = 6'd14;
  localparam logic [5:0] OpOr    = 6'd15;
  localparam logic [5:0] OpXor   = 6'd16;
  localparam logic [5:0] OpNot   = 6'd17;
  localparam logic [5:0] OpCmp   = 6'd18;
  localparam logic [5:0] OpHlt   = 6'd19;
  localparam logic [5:0] OpLea   = 6'd20;
  localparam logic [5:0] OpShr   = 6'd21;
  localparam logic [5:0] OpShl   = 6'd22;
  localparam logic [5:0] OpSar   = 6'd23;
  localparam logic [5:0] OpShra  = 6'd24;
  localparam logic [5:0] OpMod   = 6'd25;
  localparam logic [5:0] OpNeg   = 6'd26;
  localparam logic [5:0] OpInc   = 6'd27;
  localparam logic [5:0] OpDec   = 6'd28;
  localparam logic [5:0] OpJs    = 6'd29;
  localparam logic [5:0] OpJc    = 6'd30;
  localparam logic [5:0] OpJnc   = 6'd31;
  localparam logic [5:0] OpJns   = 6'd32;
  localparam logic [5:0] OpTest  = 6'd33;
  localparam logic [5:0] OpMov   = 6'd34;

  typedef struct packed {
    logic [5:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  c;
    logic        divide;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        sign_out;
    logic        carry_out;
    logic        reg_written;
    logic [7:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [6:0]  stack_count;
    logic        stack_overflow;
    logic        halt;
  } res_t;

endpackage
`default_nettype wire

### rtl/vmx_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/vmx_div.sv
// iterative 32-bit unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module vmx_div import vmx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output      logic        busy_o,
  output      logic [31:0] quot_o,
  output      logic [31:0] rem_o
);

  logic [31:0] quo_q, rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### rtl/vmx_front.sv
// front end: two entry instruction queue with opcode classification
`timescale 1ns / 1ps
`default_nettype none
module vmx_front import vmx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output      logic        full_o,
  input  wire logic [5:0]  mode_i,
  input  wire logic [31:0] op_a_i,
  input  wire logic [31:0] op_b_i,
  input  wire logic [7:0]  op_c_i,
  output      fq_t         head_o,
  input  wire logic        pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  item_t      item_in;

  always_comb begin
    item_in.mode   = mode_i;
    item_in.a      = op_a_i;
    item_in.b      = op_b_i;
    item_in.c      = op_c_i;
    item_in.divide = (mode_i == OpDiv) || (mode_i == OpMod);
  end

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

### rtl/vmx_back.sv
// back end: sequencer that executes one instruction against the machine state
`timescale 1ns / 1ps
`default_nettype none
module vmx_back import vmx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fq_t         head_i,
  output      logic        pop_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output      logic        out_valid_o,
  output      res_t        res_o,
  input  wire logic        out_pop_i
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_DIV} state_e;

  state_e            state_q, state_d;
  item_t             cur_q;
  logic [SpW-1:0]    sp_q, sp_n;
  logic [31:0]       pc_q, pc_n;
  logic              sign_q, sign_n, carry_q, carry_n;
  logic [NumRegs-1:0] rf_vld_q;
  logic              out_valid_q;
  res_t              res_q, res_n;
  logic              ra_ok_q, rb_ok_q, mb_ok_q;
  logic [MemAw-1:0]  clr_cnt_q;

  logic [31:0] rf_a_rdata, rf_b_rdata, stk_rdata;
  logic [7:0]  mem_rdata;
  logic [31:0] ra, rb, mb;
  logic [4:0]  sh;
  logic        out_free, commit, div_start, div_busy;
  logic [31:0] quot, rem;
  logic        wr_req, wr_ok, mem_we, push_we, ovf, halt;
  logic [31:0] wr_tgt, wr_val, push_val;
  logic [StkAw-1:0] stk_raddr;
  logic        rf_we, m_we;
  logic [MemAw-1:0] m_waddr;
  logic [RegAw-1:0] rf_a_raddr, rf_b_raddr;
  logic [MemAw-1:0] m_raddr;

  assign out_free = !out_valid_q || out_pop_i;
  assign ra = ra_ok_q ? rf_a_rdata : 32'd0;
  assign rb = rb_ok_q ? rf_b_rdata : 32'd0;
  assign mb = mb_ok_q ? {24'd0, mem_rdata} : 32'd0;
  assign sh = cur_q.b[4:0] & ShiftMask;
  assign stk_raddr = StkAw'(sp_q - SpW'(1));

  // read addresses follow the item in flight while it waits to commit
  assign rf_a_raddr = pop_o ? head_i.item.a[RegAw-1:0] : cur_q.a[RegAw-1:0];
  assign rf_b_raddr = pop_o ? head_i.item.b[RegAw-1:0] : cur_q.b[RegAw-1:0];
  assign m_raddr    = pop_o ? head_i.item.b[MemAw-1:0] : cur_q.b[MemAw-1:0];

  // effects of the instruction in flight
  always_comb begin
    wr_req   = 1'b0;
    wr_tgt   = {24'd0, cur_q.c};
    wr_val   = '0;
    mem_we   = 1'b0;
    push_we  = 1'b0;
    push_val = ra;
    ovf      = 1'b0;
    halt     = 1'b0;
    pc_n     = pc_q;
    sign_n   = sign_q;
    carry_n  = carry_q;
    sp_n     = sp_q;
    if (state_q == S_DIV) begin
      wr_req = 1'b1;
      wr_val = (cur_q.mode == OpMod) ? rem : quot;
    end else begin
      case (cur_q.mode)
        OpLoad: begin
          wr_req = 1'b1; wr_tgt = cur_q.a; wr_val = mb;
        end
        OpStore: mem_we = (cur_q.b < 32'(MemBytes));
        OpAdd:  begin wr_req = 1'b1; wr_val = ra + rb; end
        OpSub:  begin wr_req = 1'b1; wr_val = ra - rb; end
        OpMul:  begin wr_req = 1'b1; wr_val = ra * rb; end
        OpJmp:  pc_n = cur_q.a;
        OpJz:   if (ra == 32'd0) pc_n = cur_q.b;
        OpJnz:  if (ra != 32'd0) pc_n = cur_q.b;
        OpCall: begin
          push_val = pc_q + 32'd1;
          pc_n     = cur_q.a;
          if (sp_q < SpW'(StackDepth)) begin
            push_we = 1'b1;
            sp_n    = sp_q + SpW'(1);
          end else begin
            ovf = 1'b1;
          end
        end
        OpRet: begin
          if (sp_q != '0) begin
            sp_n = sp_q - SpW'(1);
            pc_n = stk_rdata;
          end
        end
        OpPush: begin
          if (sp_q < SpW'(StackDepth)) begin
            push_we = 1'b1;
            sp_n    = sp_q + SpW'(1);
          end else begin
            ovf = 1'b1;
          end
        end
        OpPop: begin
          if (sp_q != '0) begin
            sp_n   = sp_q - SpW'(1);
            wr_req = 1'b1;
            wr_tgt = cur_q.a;
            wr_val = stk_rdata;
          end
        end
        OpAnd:  begin wr_req = 1'b1; wr_val = ra & rb; end
        OpOr:   begin wr_req = 1'b1; wr_val = ra | rb; end
        OpXor:  begin wr_req = 1'b1; wr_val = ra ^ rb; end
        OpNot:  begin wr_req = 1'b1; wr_tgt = cur_q.b; wr_val = ~ra; end
        OpCmp: begin
          sign_n  = $signed(ra) < $signed(rb);
          carry_n = ra >= rb;
        end
        OpHlt:  halt = 1'b1;
        OpLea:  begin wr_req = 1'b1; wr_tgt = cur_q.a; wr_val = cur_q.b; end
        OpShr:  begin wr_req = 1'b1; wr_val = ra >> sh; end
        OpShl, OpShra: begin wr_req = 1'b1; wr_val = ra << sh; end
        OpSar:  begin wr_req = 1'b1; wr_val = 32'($signed(ra) >>> sh); end
        OpNeg:  begin wr_req = 1'b1; wr_tgt = cur_q.b; wr_val = 32'd0 - ra; end
        OpInc:  begin wr_req = 1'b1; wr_tgt = cur_q.a; wr_val = ra + 32'd1; end
        OpDec:  begin wr_req = 1'b1; wr_tgt = cur_q.a; wr_val = ra - 32'd1; end
        OpJs:   if (sign_q) pc_n = cur_q.a;
        OpJc:   if (carry_q) pc_n = cur_q.a;
        OpJnc:  if (!carry_q) pc_n = cur_q.a;
        OpJns:  if (!sign_q) pc_n = cur_q.a;
        OpTest: begin
          sign_n  = ra[31];
          carry_n = ra != 32'd0;
        end
        OpMov:  begin wr_req = 1'b1; wr_tgt = cur_q.b; wr_val = ra; end
        default: ;
      endcase
    end
    wr_ok = wr_req && (wr_tgt < 32'(NumRegs));
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == MemAw'(MemBytes - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur_q.divide && rb != 32'd0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_n.next_pc        = pc_n;
    res_n.sign_out       = sign_n;
    res_n.carry_out      = carry_n;
    res_n.reg_written    = wr_ok;
    res_n.reg_index      = wr_ok ? wr_tgt[7:0] : 8'd0;
    res_n.reg_value      = wr_ok ? wr_val : 32'd0;
    res_n.mem_written    = mem_we;
    res_n.stack_count    = 7'(sp_n);
    res_n.stack_overflow = ovf;
    res_n.halt           = halt;
  end

  assign rf_we   = commit && wr_ok;
  assign m_we    = (state_q == S_CLEAR) || (commit && mem_we);
  assign m_waddr = (state_q == S_CLEAR) ? clr_cnt_q : cur_q.b[MemAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sp_q        <= '0;
      pc_q        <= '0;
      sign_q      <= 1'b0;
      carry_q     <= 1'b0;
      rf_vld_q    <= '0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + MemAw'(1);
      end
      if (commit) begin
        sp_q    <= sp_n;
        pc_q    <= pc_n;
        sign_q  <= sign_n;
        carry_q <= carry_n;
      end
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      if (rf_we) begin
        rf_vld_q[wr_tgt[RegAw-1:0]] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q   <= head_i.item;
      ra_ok_q <= (head_i.item.a < 32'(NumRegs)) && rf_vld_q[head_i.item.a[RegAw-1:0]];
      rb_ok_q <= (head_i.item.b < 32'(NumRegs)) && rf_vld_q[head_i.item.b[RegAw-1:0]];
      mb_ok_q <= head_i.item.b < 32'(MemBytes);
    end
    if (commit) begin
      res_q <= res_n;
    end
  end

  // two copies of the register file give two read ports
  vmx_ram #(.WIDTH(32), .DEPTH(NumRegs)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (wr_tgt[RegAw-1:0]),
    .wdata_i (wr_val),
    .raddr_i (rf_a_raddr),
    .rdata_o (rf_a_rdata)
  );

  vmx_ram #(.WIDTH(32), .DEPTH(NumRegs)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (wr_tgt[RegAw-1:0]),
    .wdata_i (wr_val),
    .raddr_i (rf_b_raddr),
    .rdata_o (rf_b_rdata)
  );

  vmx_ram #(.WIDTH(8), .DEPTH(MemBytes)) u_mem (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i ((state_q == S_CLEAR) ? 8'd0 : ra[7:0]),
    .raddr_i (m_raddr),
    .rdata_o (mem_rdata)
  );

  vmx_ram #(.WIDTH(32), .DEPTH(StackDepth)) u_stk (
    .clk_i   (clk_i),
    .we_i    (commit && push_we),
    .waddr_i (sp_q[StkAw-1:0]),
    .wdata_i (push_val),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  vmx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ra),
    .divisor_i  (rb),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

### rtl/register_vm_instruction_execute.sv
// top level of the register vm instruction execute block
//
// usage: decoded instructions (mode, op_a, op_b, op_c) go in through a queue
// style port: an item is taken when push is high and full is low. results come
// out the same way: the oldest result sits on the result ports while empty is
// low and leaves on a clock edge with pop high.
// a two entry front queue takes items while the back end works, so the sender
// only sees full when two items wait, behind the one in execution or the memory clear.
// the back end reads registers, memory and stack as it takes an item from the
// queue and executes it in its execute step; it takes no new item until that
// one commits. div and mod with a nonzero divisor also run the iterative divider.
// the result register frees when popped; while it is held the back end waits
// at its execute or divide step and the front queue fills, then full rises.
// reset: all control state clears, the pc goes to zero, and the byte memory is
// cleared one byte per cycle, all 4096 bytes, during which no item executes
// (items may still queue up; start_pc writes are taken at any time and load
// the pc directly).
`timescale 1ns / 1ps
`default_nettype none
module register_vm_instruction_execute import vmx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [5:0]  mode_i,
  input  wire logic [31:0] op_a_i,
  input  wire logic [31:0] op_b_i,
  input  wire logic [7:0]  op_c_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [31:0] next_pc_o,
  output      logic        sign_out_o,
  output      logic        carry_out_o,
  output      logic        reg_written_o,
  output      logic [7:0]  reg_index_o,
  output      logic [31:0] reg_value_o,
  output      logic        mem_written_o,
  output      logic [6:0]  stack_count_o,
  output      logic        stack_overflow_o,
  output      logic        halt_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  fq_t  head;
  logic head_pop;
  logic out_valid;
  res_t res;

  // front end: accepts and classifies items
  vmx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .mode_i (mode_i),
    .op_a_i (op_a_i),
    .op_b_i (op_b_i),
    .op_c_i (op_c_i),
    .head_o (head),
    .pop_i  (head_pop)
  );

  // back end: executes against registers, memory, stack and flags
  vmx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (head_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid),
    .res_o       (res),
    .out_pop_i   (pop)
  );

  assign empty            = !out_valid;
  assign next_pc_o        = res.next_pc;
  assign sign_out_o       = res.sign_out;
  assign carry_out_o      = res.carry_out;
  assign reg_written_o    = res.reg_written;
  assign reg_index_o      = res.reg_index;
  assign reg_value_o      = res.reg_value;
  assign mem_written_o    = res.mem_written;
  assign stack_count_o    = res.stack_count;
  assign stack_overflow_o = res.stack_overflow;
  assign halt_o           = res.halt;

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// testbench for the register vm instruction execute block
`timescale 1ns / 1ps
module tb_top;
  import vmx_pkg::*;

  localparam logic [5:0] OpNop  = 6'd0;
  localparam logic [5:0] OpLog  = 6'd35;
  localparam logic [5:0] OpHost = 6'd36;
  localparam logic [5:0] OpLast = 6'd63;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [5:0]  mode_i = '0;
  logic [31:0] op_a_i = '0;
  logic [31:0] op_b_i = '0;
  logic [7:0]  op_c_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] next_pc_o;
  logic        sign_out_o;
  logic        carry_out_o;
  logic        reg_written_o;
  logic [7:0]  reg_index_o;
  logic [31:0] reg_value_o;
  logic        mem_written_o;
  logic [6:0]  stack_count_o;
  logic        stack_overflow_o;
  logic        halt_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  register_vm_instruction_execute dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .mode_i(mode_i), .op_a_i(op_a_i), .op_b_i(op_b_i), .op_c_i(op_c_i),
    .empty(empty), .pop(pop),
    .next_pc_o(next_pc_o), .sign_out_o(sign_out_o), .carry_out_o(carry_out_o),
    .reg_written_o(reg_written_o), .reg_index_o(reg_index_o),
    .reg_value_o(reg_value_o), .mem_written_o(mem_written_o),
    .stack_count_o(stack_count_o), .stack_overflow_o(stack_overflow_o),
    .halt_o(halt_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial forever #5 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("register_vm_instruction_execute: mismatch");
    $finish;
  end

  // shadow machine state, updated as each item is accepted
  logic [31:0] shadow_regs [NumRegs];
  logic [7:0]  shadow_mem [MemBytes];
  logic [31:0] shadow_stack [StackDepth];
  int unsigned shadow_sp;
  logic [31:0] shadow_pc;
  logic        shadow_sign, shadow_carry;

  res_t        pending_results [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          overflows_seen = 0;

  // executes one instruction on the shadow state and returns what the block should report
  function automatic res_t execute_instr(logic [5:0] m, logic [31:0] a, logic [31:0] b,
                                         logic [7:0] c);
    res_t        r;
    logic [31:0] ra, rb, val;
    logic [31:0] dst;
    logic        do_wr;
    logic [4:0]  sh;
    r = '0;
    ra = (a < NumRegs) ? shadow_regs[a[RegAw-1:0]] : 32'd0;
    rb = (b < NumRegs) ? shadow_regs[b[RegAw-1:0]] : 32'd0;
    sh = b[4:0] & ShiftMask;
    do_wr = 1'b0;
    dst = {24'd0, c};
    val = '0;
    case (m)
      OpLoad: begin
        do_wr = 1'b1; dst = a;
        val = (b < MemBytes) ? {24'd0, shadow_mem[b[MemAw-1:0]]} : 32'd0;
      end
      OpStore: if (b < MemBytes) begin
        shadow_mem[b[MemAw-1:0]] = ra[7:0]; r.mem_written = 1'b1;
      end
      OpAdd: begin do_wr = 1'b1; val = ra + rb; end
      OpSub: begin do_wr = 1'b1; val = ra - rb; end
      OpMul: begin do_wr = 1'b1; val = ra * rb; end
      OpDiv: if (rb != 0) begin do_wr = 1'b1; val = ra / rb; end
      OpMod: if (rb != 0) begin do_wr = 1'b1; val = ra % rb; end
      OpJmp: shadow_pc = a;
      OpJz:  if (ra == 0) shadow_pc = b;
      OpJnz: if (ra != 0) shadow_pc = b;
      OpCall: begin
        if (shadow_sp < StackDepth) begin
          shadow_stack[shadow_sp[StkAw-1:0]] = shadow_pc + 32'd1; shadow_sp++;
        end else r.stack_overflow = 1'b1;
        shadow_pc = a;
      end
      OpRet: if (shadow_sp > 0) begin
        shadow_sp--; shadow_pc = shadow_stack[shadow_sp[StkAw-1:0]];
      end
      OpPush: begin
        if (shadow_sp < StackDepth) begin
          shadow_stack[shadow_sp[StkAw-1:0]] = ra; shadow_sp++;
        end else r.stack_overflow = 1'b1;
      end
      OpPop: if (shadow_sp > 0) begin
        shadow_sp--; do_wr = 1'b1; dst = a; val = shadow_stack[shadow_sp[StkAw-1:0]];
      end
      OpAnd: begin do_wr = 1'b1; val = ra & rb; end
      OpOr:  begin do_wr = 1'b1; val = ra | rb; end
      OpXor: begin do_wr = 1'b1; val = ra ^ rb; end
      OpNot: begin do_wr = 1'b1; dst = b; val = ~ra; end
      OpCmp: begin
        shadow_sign = $signed(ra) < $signed(rb);
        shadow_carry = ra >= rb;
      end
      OpHlt: r.halt = 1'b1;
      OpLea: begin do_wr = 1'b1; dst = a; val = b; end
      OpShr: begin do_wr = 1'b1; val = ra >> sh; end
      OpShl, OpShra: begin do_wr = 1'b1; val = ra << sh; end
      OpSar: begin do_wr = 1'b1; val = $unsigned($signed(ra) >>> sh); end
      OpNeg: begin do_wr = 1'b1; dst = b; val = 32'd0 - ra; end
      OpInc: begin do_wr = 1'b1; dst = a; val = ra + 32'd1; end
      OpDec: begin do_wr = 1'b1; dst = a; val = ra - 32'd1; end
      OpJs:  if (shadow_sign) shadow_pc = a;
      OpJc:  if (shadow_carry) shadow_pc = a;
      OpJnc: if (!shadow_carry) shadow_pc = a;
      OpJns: if (!shadow_sign) shadow_pc = a;
      OpTest: begin
        shadow_sign = ra[31];
        shadow_carry = ra != 0;
      end
      OpMov: begin do_wr = 1'b1; dst = b; val = ra; end
      default: ;  // nop, log, host call and unused modes
    endcase
    if (do_wr && dst < NumRegs) begin
      shadow_regs[dst[RegAw-1:0]] = val;
      r.reg_written = 1'b1;
      r.reg_index = dst[7:0];
      r.reg_value = val;
    end
    r.next_pc = shadow_pc;
    r.sign_out = shadow_sign;
    r.carry_out = shadow_carry;
    r.stack_count = shadow_sp[6:0];
    return r;
  endfunction

  // offers one item, with random idle cycles first, and records its expected result
  task automatic send_instr(logic [5:0] m, logic [31:0] a, logic [31:0] b, logic [7:0] c);
    res_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= m; op_a_i <= a; op_b_i <= b; op_c_i <= c;
    do @(posedge clk_i); while (full);
    exp_res = execute_instr(m, a, b, c);
    if (exp_res.stack_overflow) overflows_seen++;
    pending_results.push_back(exp_res);
    items_sent++;
  endtask

  // lets the block run dry: all results back, then room for a trailing divide
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_start_pc(logic [31:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_pc = value;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver: random pops, long hold-off when asked, and the result check
  always @(posedge clk_i) begin
    res_t exp_res;
    if (pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, pc %h", $realtime, next_pc_o);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("next_pc", exp_res.next_pc, next_pc_o);
        check_field("sign_out", exp_res.sign_out, sign_out_o);
        check_field("carry_out", exp_res.carry_out, carry_out_o);
        check_field("reg_written", exp_res.reg_written, reg_written_o);
        check_field("reg_index", exp_res.reg_index, reg_index_o);
        check_field("reg_value", exp_res.reg_value, reg_value_o);
        check_field("mem_written", exp_res.mem_written, mem_written_o);
        check_field("stack_count", exp_res.stack_count, stack_count_o);
        check_field("stack_overflow", exp_res.stack_overflow, stack_overflow_o);
        check_field("halt", exp_res.halt, halt_o);
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // operand mostly near the register range, some at the memory edge, else any value
  function automatic logic [31:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(NumRegs + 1);
    if (sel < 80) return $urandom_range(MemBytes + 4, MemBytes - 6);
    return $urandom;
  endfunction

  task automatic random_instr();
    logic [5:0]  m;
    logic [31:0] a, b;
    logic [7:0]  c;
    m = ($urandom_range(99) < 92) ? 6'($urandom_range(34)) : 6'($urandom_range(63, 35));
    a = pick_operand();
    b = pick_operand();
    c = ($urandom_range(99) < 80) ? 8'($urandom_range(NumRegs + 1)) : 8'($urandom);
    // memory ops and immediates want addresses and values rather than indexes
    if (m == OpLoad || m == OpStore) begin
      if ($urandom_range(99) < 80) b = $urandom_range(MemBytes + 2);
    end else if (m == OpLea && $urandom_range(1)) begin
      b = $urandom;
    end else if ((m == OpShr || m == OpShl || m == OpSar || m == OpShra) && $urandom_range(1)) begin
      b = $urandom;
    end
    send_instr(m, a, b, c);
  endtask

  // alu and memory corners
  task automatic test_alu_corners();
    send_instr(OpLea, 32'd1, 32'hFFFF_FFFF, 8'd0);
    send_instr(OpLea, 32'd2, 32'h8000_0000, 8'd0);
    send_instr(OpLea, 32'd3, 32'd1, 8'd0);
    send_instr(OpAdd, 32'd1, 32'd3, 8'd4);     // wraps to zero
    send_instr(OpSub, 32'd0, 32'd3, 8'd5);
    send_instr(OpMul, 32'd1, 32'd2, 8'd6);
    send_instr(OpDiv, 32'd1, 32'd0, 8'd7);     // divide by zero keeps r7
    send_instr(OpDiv, 32'd1, 32'd2, 8'd7);
    send_instr(OpMod, 32'd1, 32'd4, 8'd8);     // modulo by zero
    send_instr(OpMod, 32'd1, 32'd2, 8'd8);
    send_instr(OpStore, 32'd1, 32'd4095, 8'd0);
    send_instr(OpStore, 32'd1, 32'd4096, 8'd0); // store out of range dropped
    send_instr(OpLoad, 32'd9, 32'd4095, 8'd0);
    send_instr(OpLoad, 32'd9, 32'hFFFF_FFFF, 8'd0);
    send_instr(OpNot, 32'd2, 32'd10, 8'd0);
    send_instr(OpNeg, 32'd2, 32'd11, 8'd0);
    send_instr(OpInc, 32'd1, 32'd0, 8'd0);
    send_instr(OpDec, 32'd0, 32'd0, 8'd0);
    send_instr(OpSar, 32'd2, 32'hFFFF_FFFF, 8'd12); // shift amount masked to 31
    send_instr(OpShr, 32'd2, 32'd33, 8'd13);
    send_instr(OpShl, 32'd3, 32'd31, 8'd14);
    send_instr(OpShra, 32'd3, 32'd4, 8'd15);
    send_instr(OpAnd, 32'd1, 32'd2, 8'd255);  // destination out of range
    send_instr(OpOr, 32'd200, 32'd2, 8'd12);  // source out of range reads zero
    send_instr(OpXor, 32'd1, 32'd2, 8'd13);
  endtask

  // compares, tests, jumps, moves, halt and the no-op modes
  task automatic test_flags_and_jumps();
    send_instr(OpCmp, 32'd2, 32'd3, 8'd0);
    send_instr(OpJs, 32'h0000_0100, 32'd0, 8'd0);
    send_instr(OpJc, 32'h0000_0200, 32'd0, 8'd0);
    send_instr(OpJnc, 32'h0000_0300, 32'd0, 8'd0);
    send_instr(OpJns, 32'h0000_0400, 32'd0, 8'd0);
    send_instr(OpTest, 32'd0, 32'd0, 8'd0);
    send_instr(OpJnc, 32'hFFFF_FFFF, 32'd0, 8'd0);
    send_instr(OpTest, 32'd2, 32'd0, 8'd0);
    send_instr(OpJz, 32'd0, 32'h1234_5678, 8'd0);
    send_instr(OpJnz, 32'd0, 32'h0000_0010, 8'd0);
    send_instr(OpJnz, 32'd2, 32'hFFFF_FFFE, 8'd0);
    send_instr(OpJmp, 32'h0000_0000, 32'd0, 8'd0);
    send_instr(OpMov, 32'd2, 32'd200, 8'd0);
    send_instr(OpMov, 32'd2, 32'd15, 8'd0);
    send_instr(OpHlt, 32'd0, 32'd0, 8'd0);
    send_instr(OpLog, 32'd1, 32'd2, 8'd3);
    send_instr(OpHost, 32'd1, 32'd2, 8'd3);
    send_instr(OpLast, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_instr(OpNop, 32'd0, 32'd0, 8'd0);
  endtask

  // empty stack, fill to overflow, call on a full stack, unwind
  task automatic test_stack_bounds();
    send_instr(OpPop, 32'd5, 32'd0, 8'd0);
    send_instr(OpRet, 32'd0, 32'd0, 8'd0);
    send_instr(OpCall, 32'h0000_0040, 32'd0, 8'd0);
    for (int i = 0; i < StackDepth; i++) send_instr(OpPush, 32'd1, 32'd0, 8'd0);
    send_instr(OpCall, 32'h0000_0080, 32'd0, 8'd0);
    send_instr(OpPop, 32'd250, 32'd0, 8'd0);   // bad register still pops
    send_instr(OpCall, 32'hFFFF_FFFF, 32'd0, 8'd0);
    send_instr(OpRet, 32'd0, 32'd0, 8'd0);
    for (int i = 0; i < StackDepth; i++) send_instr(OpPop, 32'd6, 32'd0, 8'd0);
  endtask

  // the receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) random_instr();
    drain_results();
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      random_instr();
      if (i % 250 == 249) drain_results();  // sender pauses until all results are in
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) shadow_regs[i] = '0;
    for (int i = 0; i < MemBytes; i++) shadow_mem[i] = '0;
    shadow_sp = 0;
    shadow_pc = '0;
    shadow_sign = 1'b0;
    shadow_carry = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_start_pc(32'h0000_0000);
    test_alu_corners();
    test_flags_and_jumps();
    test_stack_bounds();

    send_idle_pct = 35;
    recv_idle_pct = 58;
    write_start_pc(32'hFFFF_FFFF);
    test_backpressure();
    test_random_mix(650);

    send_idle_pct = 58;
    recv_idle_pct = 35;
    write_start_pc($urandom);
    test_random_mix(650);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_start_pc(32'h7FFF_FFFF);
    test_random_mix(650);
    drain_results();

    $display("ran %0d instructions over four start_pc settings, %0d results checked",
             items_sent, results_seen);
    $display("covered all opcodes, stack overflow %0d times, long receiver stall", overflows_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("register_vm_instruction_execute: match");
    end else begin
      $display("register_vm_instruction_execute: mismatch");
    end
    $finish;
  end

endmodule
